// ===== src/sss_pkg.sv =====
// Package with constants, types and the segment table for the six-digit scan driver.
`timescale 1ns / 1ps
package sss_pkg;

    localparam int NUM_DIGITS  = 6;
    localparam int MAX_RESULTS = 6;
    localparam int DIGIT_CNT   = (NUM_DIGITS < 1) ? 1 :
                                 (NUM_DIGITS > MAX_RESULTS) ? MAX_RESULTS : NUM_DIGITS;
    localparam int IDX_W       = (DIGIT_CNT > 1) ? $clog2(DIGIT_CNT) : 1;

    localparam int VALUE_W     = 20;
    localparam int IN_DATA_W   = 24;
    localparam int SEG_W       = 8;
    localparam int SEL_W       = 6;
    localparam int OUT_DATA_W  = 16;

    // Reciprocal of ten scaled by 2^23, exact for every 20-bit dividend.
    localparam int DIV10_SHIFT = 23;
    localparam logic [VALUE_W-1:0] DIV10_MUL = VALUE_W'(838861);
    localparam int PROD_W      = 2 * VALUE_W;
    localparam int QUOT_W      = PROD_W - DIV10_SHIFT;

    typedef struct packed {
        logic [3:0]       digit;
        logic [IDX_W-1:0] idx;
        logic             last;
    } t_digit;

    // Common-anode segment patterns, active low.
    function automatic logic [SEG_W-1:0] seg_lut(input logic [3:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0:    s = 8'hA0;
            4'd1:    s = 8'hBE;
            4'd2:    s = 8'h62;
            4'd3:    s = 8'h2A;
            4'd4:    s = 8'h3C;
            4'd5:    s = 8'h29;
            4'd6:    s = 8'h21;
            4'd7:    s = 8'hBA;
            4'd8:    s = 8'h20;
            4'd9:    s = 8'h28;
            default: s = 8'hFF;
        endcase
        return s;
    endfunction

    // Active-low digit select; positions past the select field read all ones.
    function automatic logic [SEL_W-1:0] sel_lut(input logic [IDX_W-1:0] k);
        logic [SEL_W-1:0] s;
        s = {SEL_W{1'b1}};
        if (32'(k) < SEL_W) begin
            s = ~(SEL_W'(1) << k);
        end
        return s;
    endfunction

endpackage

// ===== src/six_digit_seven_segment_scan.sv =====
// Top level of the six-digit seven-segment scan driver.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata[19:0] value (upper bits ignored)
//   m_axis    out        tdata[7:0] segments_n, tdata[13:8] select_n, tlast last_digit
//
// Each input word yields six output words, ones digit first, one per cycle while
// m_axis is not stalled. A new word is taken in the cycle that the sixth digit of
// the previous one moves to the output register, so words follow on without a gap,
// paced by the single divide-by-ten step of the digit sequencer. Reset clears the
// sequencer busy flag and digit index and the output valid. A stall on m_axis holds
// the output register and pauses the sequencer; s_axis stalls too once it is busy.
`timescale 1ns / 1ps
module six_digit_seven_segment_scan
    import sss_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [19:0] value
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [7:0] segments_n, [13:8] select_n
    output logic                  m_axis_tlast    // last_digit
);

    logic             busy;
    t_digit           cur;
    logic             advance;
    logic             load;
    logic             r_out_valid;
    logic             n_out_valid;
    logic [SEG_W-1:0] r_seg;
    logic [SEL_W-1:0] r_sel;
    logic             r_last;

    assign advance       = busy && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !busy || (advance && cur.last);
    assign load          = s_axis_tvalid && s_axis_tready;

    sss_digit_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (load),
        .i_value   (s_axis_tdata[VALUE_W-1:0]),
        .i_advance (advance),
        .o_busy    (busy),
        .o_digit   (cur)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_seg  <= seg_lut(cur.digit);
            r_sel  <= sel_lut(cur.idx);
            r_last <= cur.last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'({r_sel, r_seg});
    assign m_axis_tlast  = r_last;

    a_last_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[SEG_W + DIGIT_CNT - 1] == 1'b0))
        else $error("last word does not select the top digit");

    a_sel_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $onehot(~m_axis_tdata[SEG_W + SEL_W - 1:SEG_W]))
        else $error("digit select is not a single active digit");

    a_load_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (busy && (cur.idx == '0)))
        else $error("accepted word did not restart the digit sequence");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && !busy))
        else $error("output valid or sequencer busy after reset");

endmodule

// ===== src/sss_div10.sv =====
// Divide-by-ten unit: quotient by reciprocal multiply, remainder by shift-add.
`timescale 1ns / 1ps
module sss_div10
    import sss_pkg::*;
(
    input  logic [VALUE_W-1:0] i_x,
    output logic [VALUE_W-1:0] o_quot,
    output logic [3:0]         o_rem
);

    logic [PROD_W-1:0]  prod;
    logic [VALUE_W-1:0] q;
    logic [VALUE_W-1:0] q10;
    logic [VALUE_W-1:0] diff;

    assign prod   = PROD_W'(i_x) * PROD_W'(DIV10_MUL);
    assign q      = VALUE_W'(prod[PROD_W-1:DIV10_SHIFT]);
    assign q10    = (q << 3) + (q << 1);
    assign diff   = i_x - q10;
    assign o_quot = q;
    assign o_rem  = diff[3:0];

endmodule

// ===== src/sss_digit_seq.sv =====
// Digit sequencer: holds the remaining value and peels off one decimal digit per step.
`timescale 1ns / 1ps
module sss_digit_seq
    import sss_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic [VALUE_W-1:0] i_value,
    input  logic               i_advance,
    output logic               o_busy,
    output t_digit             o_digit
);

    logic [VALUE_W-1:0] r_rest;
    logic [VALUE_W-1:0] n_rest;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   n_idx;
    logic               r_busy;
    logic               n_busy;
    logic [VALUE_W-1:0] quot;
    logic [3:0]         rem;
    logic               is_last;

    sss_div10 u_div10 (
        .i_x    (r_rest),
        .o_quot (quot),
        .o_rem  (rem)
    );

    assign is_last = (r_idx == IDX_W'(DIGIT_CNT - 1));

    always_comb begin
        n_rest = r_rest;
        n_idx  = r_idx;
        n_busy = r_busy;
        if (i_load) begin
            n_rest = i_value;
            n_idx  = '0;
            n_busy = 1'b1;
        end else if (i_advance) begin
            n_rest = quot;
            n_idx  = r_idx + 1'b1;
            n_busy = !is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_busy <= 1'b0;
        end else begin
            r_idx  <= n_idx;
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rest <= n_rest;
    end

    assign o_busy        = r_busy;
    assign o_digit.digit = rem;
    assign o_digit.idx   = r_idx;
    assign o_digit.last  = is_last;

endmodule

// ===== tb/six_digit_seven_segment_scan_test.sv =====
// Self-checking testbench for the six-digit seven-segment scan driver.
`timescale 1ns / 1ps
module six_digit_seven_segment_scan_test;
    import sss_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int UPPER_W     = IN_DATA_W - VALUE_W;
    localparam int HOLD_CYCLES = 90;
    localparam int DRAIN_LIMIT = 20000;

    localparam logic [SEG_W-1:0] SEGMENT_PATTERN [10] = '{
        8'hA0, 8'hBE, 8'h62, 8'h2A, 8'h3C, 8'h29, 8'h21, 8'hBA, 8'h20, 8'h28
    };

    typedef struct packed {
        logic [SEG_W-1:0] segments_n;
        logic [SEL_W-1:0] select_n;
        logic             last_digit;
    } t_digit_word;

    class digit_scoreboard;
        t_digit_word pending[$];
        int unsigned errors        = 0;
        int unsigned values_seen   = 0;
        int unsigned words_checked = 0;

        function void note_value(logic [VALUE_W-1:0] value);
            logic [VALUE_W-1:0] rest;
            t_digit_word        w;
            int                 k;
            rest = value;
            for (k = 0; k < DIGIT_CNT; k++) begin
                w.segments_n = SEGMENT_PATTERN[rest % 10];
                w.select_n   = (k < SEL_W) ? ~(SEL_W'(1) << k) : {SEL_W{1'b1}};
                w.last_digit = (k == DIGIT_CNT - 1);
                pending.push_back(w);
                rest = rest / 10;
            end
            values_seen++;
        endfunction

        function void check_word(logic [OUT_DATA_W-1:0] tdata, logic tlast);
            t_digit_word want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual tdata %04h tlast %b",
                         $time, tdata, tlast);
                errors++;
                return;
            end
            want = pending.pop_front();
            words_checked++;
            if (tdata[SEG_W-1:0] !== want.segments_n) begin
                $display("%0t: wrong segments_n, expected %02h, actual %02h",
                         $time, want.segments_n, tdata[SEG_W-1:0]);
                errors++;
            end
            if (tdata[SEG_W+SEL_W-1:SEG_W] !== want.select_n) begin
                $display("%0t: wrong select_n, expected %02h, actual %02h",
                         $time, want.select_n, tdata[SEG_W+SEL_W-1:SEG_W]);
                errors++;
            end
            if (tdata[OUT_DATA_W-1:SEG_W+SEL_W] !== '0) begin
                $display("%0t: wrong tdata padding, expected 0, actual %0h",
                         $time, tdata[OUT_DATA_W-1:SEG_W+SEL_W]);
                errors++;
            end
            if (tlast !== want.last_digit) begin
                $display("%0t: wrong last_digit, expected %b, actual %b",
                         $time, want.last_digit, tlast);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // [19:0] value
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // [7:0] segments_n, [13:8] select_n
    logic                  m_axis_tlast;         // last_digit

    digit_scoreboard board = new;
    bit              rx_idle_on  = 1'b1;
    bit              tx_idle_on  = 1'b1;
    int              hold_cycles = 0;

    six_digit_seven_segment_scan uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            board.check_word(m_axis_tdata, m_axis_tlast);
        end
    end

    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                hold_cycles--;
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                if (rx_idle_on && $urandom_range(0, 9) == 0) begin
                    stall_left = $urandom_range(1, 14);
                end
            end
        end
    end

    initial begin
        #3_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_value(input logic [IN_DATA_W-1:0] word);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_value(word[VALUE_W-1:0]);
    endtask

    task automatic sender_gap();
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= IN_DATA_W'($urandom);
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    task automatic wait_for_drain();
        int n;
        s_axis_tvalid <= 1'b0;
        for (n = 0; n < DRAIN_LIMIT && board.pending.size() != 0; n++) @(posedge i_clk);
        repeat (DIGIT_CNT + 4) @(posedge i_clk);
    endtask

    function automatic logic [IN_DATA_W-1:0] random_word();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(0, 5))
            0:       v = VALUE_W'($urandom_range(0, 99));
            1:       v = VALUE_W'($urandom_range(999_990, 1_048_575));
            2:       v = VALUE_W'($urandom_range(0, 999_999));
            default: v = VALUE_W'($urandom);
        endcase
        return {UPPER_W'($urandom), v};
    endfunction

    initial begin
        logic [IN_DATA_W-1:0] directed_words [$];
        int                   i;
        directed_words = '{
            24'h000000, 24'h000001, 24'd9, 24'd10, 24'd123456, 24'd654321,
            24'd987654, 24'd999999, 24'd1000000, 24'h0FFFFF, 24'hFFFFFF,
            24'hA00007, 24'h03F000, 24'd111111, 24'd500005, 24'd234567,
            24'd890123
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_words[j]) begin
            sender_gap();
            send_value(directed_words[j]);
        end
        wait_for_drain();

        // The output side holds off while words keep coming, so the input must stall.
        hold_cycles = HOLD_CYCLES;
        tx_idle_on  = 1'b0;
        for (i = 0; i < 24; i++) send_value(random_word());
        tx_idle_on  = 1'b1;
        wait_for_drain();

        for (i = 0; i < 300; i++) begin
            sender_gap();
            send_value(random_word());
        end

        rx_idle_on = 1'b0;
        tx_idle_on = 1'b0;
        for (i = 0; i < 30; i++) send_value(random_word());
        wait_for_drain();

        if (board.pending.size() != 0) begin
            $display("%0t: %0d digit words never arrived, expected 0 left over",
                     $time, board.pending.size());
            board.errors++;
        end

        $display("Ran %0d values through the scan driver and checked %0d digit words.",
                 board.values_seen, board.words_checked);
        $display("Covered digit extremes, wrapped values, long output stalls and idle gaps.");
        if (board.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/sss_pkg.sv
src/sss_div10.sv
src/sss_digit_seq.sv
src/six_digit_seven_segment_scan.sv
tb/six_digit_seven_segment_scan_test.sv
